>>> sv/grsv_pkg.sv
// Package for the graph record stream validator.
// Holds format constants, register indexes, status codes and the snapshot type.
// No dependencies.
package grsv_pkg;

  localparam logic [31:0] MagicWord      = 32'h4647_445A;
  localparam int unsigned HeaderBytes    = 16;
  localparam int unsigned RecordBytes    = 40;
  localparam logic [31:0] TrailingDetail = 32'h0000_FFFF;
  localparam logic [31:0] NodeDetailBase = 32'd10;

  localparam logic [5:0]  SizeFirst      = 6'd32;
  localparam logic [5:0]  ResvFirst      = 6'd36;
  localparam logic [5:0]  RecordLast     = 6'd39;

  // Configuration register indexes
  localparam logic [1:0] CfgExpVersion   = 2'd0;
  localparam logic [1:0] CfgMaxNodes     = 2'd1;
  localparam logic [1:0] CfgMaxStateNode = 2'd2;
  localparam logic [1:0] CfgMaxStateSum  = 2'd3;

  // Status codes
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusMalformed = 2'd1;
  localparam logic [1:0] StatusVersion   = 2'd2;
  localparam logic [1:0] StatusCapacity  = 2'd3;

  // Detail codes
  localparam logic [31:0] DetailMagic    = 32'd1;
  localparam logic [31:0] DetailResv     = 32'd3;
  localparam logic [31:0] DetailShort    = 32'd4;

  localparam int unsigned OutDataBits    = 88;

  // Stream state captured on the final word, after that word is applied
  typedef struct packed {
    logic [31:0] pos;
    logic        magic_ok;
    logic [31:0] version;
    logic        resv_zero;
    logic [31:0] count;
    logic        node_fault;
    logic [15:0] fault_node;
    logic [15:0] node_index;
    logic        walk_idle;
    logic [31:0] state_sum;
  } snap_t;

endpackage

>>> sv/graph_record_stream_validator.sv
// Top level of the graph record stream validator.
// Streaming byte parser with a verdict stage and an output register.
// Depends on grsv_pkg.
//
// Usage:
//   Feed the encoded buffer one byte per word on the s_axis channel, tlast on
//   the final byte. Each final byte yields exactly one verdict word on the
//   m_axis channel; other bytes yield nothing.
//   The byte parser takes one word per cycle while s_axis_tready is high. The
//   final byte's stream state is captured into a snapshot register, and the
//   verdict is formed from it into the output register when that register can
//   take it. Sustained rate is 1 byte per cycle while s_axis_tready is high.
//   A stalled receiver holds the verdict in the output register; the snapshot
//   register keeps a second verdict, and only then is s_axis_tready dropped.
//   Reset clears the stream state, empties both stages and loads the
//   configuration reset values (version 1, 256 nodes, 4096 state bytes per
//   node, 65536 state bytes in total). The stream state also clears itself
//   after each final byte; configuration keeps its values.
//   Write configuration through cfg_we_i/cfg_index_i/cfg_wdata_i while idle.
module graph_record_stream_validator
  import grsv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_wdata_i,
  // Input byte stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tlast,   // final_byte
  // Verdict stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] status_code, [33:2] detail, [49:34] node_total,
  // [81:50] state_total, [87:82] zero
  output logic [OutDataBits-1:0] m_axis_tdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] exp_version_q;
  logic [15:0] max_nodes_q;
  logic [31:0] max_state_node_q;
  logic [31:0] max_state_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q    <= 32'd1;
      max_nodes_q      <= 16'd256;
      max_state_node_q <= 32'd4096;
      max_state_sum_q  <= 32'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgExpVersion:   exp_version_q    <= cfg_wdata_i;
        CfgMaxNodes:     max_nodes_q      <= cfg_wdata_i[15:0];
        CfgMaxStateNode: max_state_node_q <= cfg_wdata_i;
        CfgMaxStateSum:  max_state_sum_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stream state
  // ---------------------------------------------------------------------------
  logic [31:0] pos_q,  pos_d;
  logic [31:0] hdr_q [4];
  logic [31:0] hdr_d [4];
  logic [5:0]  rec_off_q, rec_off_d;
  logic [15:0] node_idx_q, node_idx_d;
  logic [31:0] size_q, size_d;
  logic [31:0] resv_q, resv_d;
  logic [31:0] srem_q, srem_d;
  logic [31:0] sum_q, sum_d;
  logic        fault_q, fault_d;
  logic [15:0] fnode_q, fnode_d;

  // Pipeline control
  logic  snap_vld_q;
  snap_t snap_q;
  logic  out_vld_q;
  logic [OutDataBits-1:0] out_data_q;

  logic  out_move;
  logic  snap_move;
  logic  in_fire;

  assign out_move      = !out_vld_q || m_axis_tready;
  assign snap_move     = snap_vld_q && out_move;
  assign s_axis_tready = !snap_vld_q || out_move;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Next stream state for the byte on the input, before the end-of-buffer clear
  always_comb begin
    logic        walk_en;
    logic [31:0] size_c;
    logic [31:0] resv_c;
    logic [32:0] sum_ext;
    logic [1:0]  lane;

    pos_d      = (pos_q == '1) ? pos_q : pos_q + 32'd1;
    for (int i = 0; i < 4; i++) hdr_d[i] = hdr_q[i];
    rec_off_d  = rec_off_q;
    node_idx_d = node_idx_q;
    size_d     = size_q;
    resv_d     = resv_q;
    srem_d     = srem_q;
    sum_d      = sum_q;
    fault_d    = fault_q;
    fnode_d    = fnode_q;

    size_c  = size_q;
    resv_c  = resv_q;
    sum_ext = '0;
    lane    = rec_off_q[1:0];
    walk_en = (pos_q >= HeaderBytes) && !fault_q && ({16'd0, node_idx_q} != hdr_q[2]);

    if (pos_q < HeaderBytes) begin
      // Assemble the little-endian header words
      hdr_d[pos_q[3:2]][{pos_q[1:0], 3'b000} +: 8] = s_axis_tdata;
    end else if (walk_en) begin
      if (srem_q != 32'd0) begin
        // Skip opaque state bytes
        srem_d = srem_q - 32'd1;
        if (srem_q == 32'd1) node_idx_d = node_idx_q + 16'd1;
      end else begin
        if (rec_off_q >= SizeFirst && rec_off_q < ResvFirst) begin
          size_c[{lane, 3'b000} +: 8] = s_axis_tdata;
        end else if (rec_off_q >= ResvFirst) begin
          resv_c[{lane, 3'b000} +: 8] = s_axis_tdata;
        end
        size_d = size_c;
        resv_d = resv_c;
        if (rec_off_q != RecordLast) begin
          rec_off_d = rec_off_q + 6'd1;
        end else begin
          // Node header complete: check it against the limits
          rec_off_d = '0;
          sum_ext   = {1'b0, sum_q} + {1'b0, size_c};
          if (resv_c != 32'd0 || size_c > max_state_node_q ||
              sum_ext > {1'b0, max_state_sum_q}) begin
            fault_d = 1'b1;
            fnode_d = node_idx_q;
          end else begin
            sum_d  = sum_ext[31:0];
            srem_d = size_c;
            if (size_c == 32'd0) node_idx_d = node_idx_q + 16'd1;
          end
          size_d = '0;
          resv_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      for (int i = 0; i < 4; i++) hdr_q[i] <= '0;
      rec_off_q  <= '0;
      node_idx_q <= '0;
      size_q     <= '0;
      resv_q     <= '0;
      srem_q     <= '0;
      sum_q      <= '0;
      fault_q    <= 1'b0;
      fnode_q    <= '0;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        // Drop the stream state for the next buffer
        pos_q      <= '0;
        for (int i = 0; i < 4; i++) hdr_q[i] <= '0;
        rec_off_q  <= '0;
        node_idx_q <= '0;
        size_q     <= '0;
        resv_q     <= '0;
        srem_q     <= '0;
        sum_q      <= '0;
        fault_q    <= 1'b0;
        fnode_q    <= '0;
      end else begin
        pos_q      <= pos_d;
        for (int i = 0; i < 4; i++) hdr_q[i] <= hdr_d[i];
        rec_off_q  <= rec_off_d;
        node_idx_q <= node_idx_d;
        size_q     <= size_d;
        resv_q     <= resv_d;
        srem_q     <= srem_d;
        sum_q      <= sum_d;
        fault_q    <= fault_d;
        fnode_q    <= fnode_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Snapshot stage: capture the state left by the final byte
  // ---------------------------------------------------------------------------
  logic snap_load;
  assign snap_load = in_fire && s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
    end else if (snap_load) begin
      snap_vld_q <= 1'b1;
    end else if (snap_move) begin
      snap_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_load) begin
      snap_q.pos        <= pos_q;
      snap_q.magic_ok   <= (hdr_d[0] == MagicWord);
      snap_q.version    <= hdr_d[1];
      snap_q.resv_zero  <= (hdr_d[3] == 32'd0);
      snap_q.count      <= hdr_d[2];
      snap_q.node_fault <= fault_d;
      snap_q.fault_node <= fnode_d;
      snap_q.node_index <= node_idx_d;
      snap_q.walk_idle  <= (rec_off_d == 6'd0) && (srem_d == 32'd0);
      snap_q.state_sum  <= sum_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict stage: priority checks on the snapshot
  // ---------------------------------------------------------------------------
  logic [1:0]  status_c;
  logic [31:0] detail_c;
  logic [15:0] nodes_c;
  logic [31:0] sum_out_c;

  always_comb begin
    logic [32:0] len;
    logic [32:0] body_len;
    logic [15:0] cnt16;
    logic [21:0] rec_bytes;
    logic [33:0] exp_len;

    len       = {1'b0, snap_q.pos} + 33'd1;
    body_len  = len - 33'(HeaderBytes);
    cnt16     = snap_q.count[15:0];
    // count * 40 as shift-add; count is at most max_nodes where it matters
    rec_bytes = {1'b0, cnt16, 5'b00000} + {3'b000, cnt16, 3'b000};
    exp_len   = 34'(HeaderBytes) + {12'd0, rec_bytes} + {2'b00, snap_q.state_sum};

    status_c  = StatusOk;
    detail_c  = '0;
    nodes_c   = '0;
    sum_out_c = '0;

    if (snap_q.pos == '1 || len < 33'(HeaderBytes) || !snap_q.magic_ok) begin
      status_c = StatusMalformed;
      detail_c = DetailMagic;
    end else if (snap_q.version != exp_version_q) begin
      status_c = StatusVersion;
      detail_c = snap_q.version;
    end else if (!snap_q.resv_zero) begin
      status_c = StatusMalformed;
      detail_c = DetailResv;
    end else if (snap_q.count > {16'd0, max_nodes_q}) begin
      status_c = StatusCapacity;
      detail_c = snap_q.count;
    end else if ({11'd0, rec_bytes} > body_len) begin
      // Too short to hold every node header
      status_c = StatusMalformed;
      detail_c = DetailShort;
    end else if (snap_q.node_fault) begin
      status_c = StatusMalformed;
      detail_c = {16'd0, snap_q.fault_node} + NodeDetailBase;
    end else if ({16'd0, snap_q.node_index} != snap_q.count || !snap_q.walk_idle) begin
      // Buffer ended inside a node
      status_c = StatusMalformed;
      detail_c = {16'd0, snap_q.node_index} + NodeDetailBase;
    end else if ({1'b0, len} != exp_len) begin
      status_c = StatusMalformed;
      detail_c = TrailingDetail;
    end else begin
      nodes_c   = cnt16;
      sum_out_c = snap_q.state_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_move) begin
      out_vld_q <= snap_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_move) begin
      out_data_q <= {6'd0, sum_out_c, nodes_c, detail_c, status_c};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
